>>> hdl/pisc_pkg.sv
package pisc_pkg;

  // Width of the width, height and depth fields
  localparam int unsigned DimBits = 16;
  // One restoring step per cell, one quotient bit per step
  localparam int unsigned DivSteps = 32;
  localparam int unsigned BitsW = DimBits + 8;
  localparam int unsigned DimProdW = 32 + DimBits;

  localparam logic [2:0] FmtDepth    = 3'd0;
  localparam logic [2:0] FmtDepth16  = 3'd1;
  localparam logic [2:0] FmtAlpha    = 3'd2;
  localparam logic [2:0] FmtRgb      = 3'd3;
  localparam logic [2:0] FmtRgba     = 3'd4;
  localparam logic [2:0] FmtLum      = 3'd5;
  localparam logic [2:0] FmtLumAlpha = 3'd6;

  localparam logic [3:0] TypByte   = 4'd0;
  localparam logic [3:0] TypUbyte  = 4'd1;
  localparam logic [3:0] TypShort  = 4'd2;
  localparam logic [3:0] TypUshort = 4'd3;
  localparam logic [3:0] TypInt    = 4'd4;
  localparam logic [3:0] TypUint   = 4'd5;
  localparam logic [3:0] TypFloat  = 4'd6;
  localparam logic [3:0] Typ565    = 4'd7;
  localparam logic [3:0] Typ4444   = 4'd8;
  localparam logic [3:0] Typ5551   = 4'd9;

  typedef struct packed {
    logic                vld;
    logic [DimBits-1:0]  w;
    logic [DimBits-1:0]  h;
    logic [DimBits-1:0]  d;
    logic [2:0]          fmt;
    logic [3:0]          typ;
    logic [7:0]          ra;
    logic [7:0]          sa;
    logic [7:0]          ia;
    logic [31:0]         val;
    logic                ov;
    logic                zero;
    logic                low;
  } ctx_t;

  typedef struct packed {
    logic [7:0]  dvs;
    logic [7:0]  rem;
    logic [31:0] dvd;
    logic [31:0] quo;
  } div_t;

  function automatic logic [7:0] bits_per_pixel(logic [2:0] fmt, logic [3:0] typ);
    logic [7:0] cc;
    logic [7:0] bpp;
    begin
      case (fmt) inside
        FmtDepth, FmtDepth16, FmtAlpha, FmtLum: cc = 8'd1;
        FmtRgb:      cc = 8'd3;
        FmtRgba:     cc = 8'd4;
        FmtLumAlpha: cc = 8'd2;
        default:     cc = 8'd0;
      endcase
      case (typ) inside
        TypByte, TypUbyte:          bpp = cc << 3;
        TypShort, TypUshort:        bpp = cc << 4;
        TypInt, TypUint, TypFloat:  bpp = cc << 5;
        Typ565, Typ4444, Typ5551:   bpp = 8'd16;
        default:                    bpp = 8'd0;
      endcase
      return bpp;
    end
  endfunction

endpackage

>>> hdl/pisc_div_cell.sv
module pisc_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  pisc_pkg::ctx_t ctx_i,
  input  pisc_pkg::div_t div_i,
  output pisc_pkg::ctx_t ctx_o,
  output pisc_pkg::div_t div_o
);
  import pisc_pkg::*;

  ctx_t       ctx_q;
  div_t       div_q;
  div_t       div_d;
  logic [8:0] trial;
  logic       ge;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial = {div_i.rem, div_i.dvd[31]};
    ge    = trial >= {1'b0, div_i.dvs};
    div_d = div_i;
    div_d.rem = ge ? 8'(trial - {1'b0, div_i.dvs}) : trial[7:0];
    div_d.dvd = {div_i.dvd[30:0], 1'b0};
    div_d.quo = {div_i.quo[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= '0;
    end else if (en_i) begin
      ctx_q <= ctx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign ctx_o = ctx_q;
  assign div_o = div_q;

endmodule

>>> hdl/pisc_div_chain.sv
module pisc_div_chain (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  pisc_pkg::ctx_t ctx_i,
  input  pisc_pkg::div_t div_i,
  output pisc_pkg::ctx_t ctx_o,
  output pisc_pkg::div_t div_o
);
  import pisc_pkg::*;

  ctx_t ctx_w [DivSteps+1];
  div_t div_w [DivSteps+1];

  assign ctx_w[0] = ctx_i;
  assign div_w[0] = div_i;

  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    pisc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .ctx_i  (ctx_w[i]),
      .div_i  (div_w[i]),
      .ctx_o  (ctx_w[i+1]),
      .div_o  (div_w[i+1])
    );
  end

  assign ctx_o = ctx_w[DivSteps];
  assign div_o = div_w[DivSteps];

endmodule

>>> hdl/packed_image_size_calculator.sv
// Packed image size calculator. Takes one image descriptor per clock while
// the pipeline is not held and returns its byte size, wrapped to 32 bits,
// with a flag that is set when any step of the sum wrapped. The pipeline
// has two input stages, three chains of 32 divider cells (the row, slice
// and image alignments, one quotient bit per cell) and seven arithmetic
// and output stages between them. The whole pipeline holds only when the
// output register is full, downstream stalls and a result is waiting at
// the tail. While the output waits with an empty tail the pipeline still
// advances and closes up the gap. A new transfer is taken in every cycle
// that is not held. A zero width, height or depth gives a size of 0 with
// no overflow.
module packed_image_size_calculator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pisc_pkg::DimBits-1:0] width_i,
  input  logic [pisc_pkg::DimBits-1:0] height_i,
  input  logic [pisc_pkg::DimBits-1:0] depth_i,
  input  logic [2:0]                  format_code_i,
  input  logic [3:0]                  type_code_i,
  input  logic [7:0]                  row_align_i,
  input  logic [7:0]                  slice_align_i,
  input  logic [7:0]                  image_align_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [31:0]                 size_bytes_o,
  output logic                        overflow_o
);
  import pisc_pkg::*;

  ctx_t a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
  ctx_t a_d, b_d, c_d, d_d, e_d, f_d, g_d, h_d;
  ctx_t ch1_ctx, ch2_ctx, ch3_ctx;
  div_t ch1_in, ch2_in, ch3_in;
  div_t ch1_div, ch2_div, ch3_div;
  logic en;
  logic out_v_q, out_ov_q;
  logic [31:0] out_size_q;
  logic [31:0] fin_size;

  logic [BitsW-1:0]    b_bits;
  logic [32:0]         c_ceil;
  logic [40:0]         c_rowp;
  logic [DimProdW-1:0] d_prod;
  logic [32:0]         e_sum;
  logic [DimProdW-1:0] g_prod;
  logic [32:0]         h_sum;

  // Hold everything only when a finished result is stuck and another waits
  assign en          = !(out_v_q && out_stall_i && ch3_ctx.vld);
  assign in_stall_o  = !en;

  // Capture the descriptor
  always_comb begin
    a_d      = '0;
    a_d.vld  = in_valid_i;
    a_d.w    = width_i;
    a_d.h    = height_i;
    a_d.d    = depth_i;
    a_d.fmt  = format_code_i;
    a_d.typ  = type_code_i;
    a_d.ra   = row_align_i;
    a_d.sa   = slice_align_i;
    a_d.ia   = image_align_i;
    a_d.zero = (width_i == '0) || (height_i == '0) || (depth_i == '0);
  end

  // Bits per row; divide bytes by the row alignment, keep the sub-byte flag
  always_comb begin
    b_d     = a_q;
    b_bits  = BitsW'(a_q.w) * BitsW'(bits_per_pixel(a_q.fmt, a_q.typ));
    b_d.val = 32'(b_bits >> 3);
    b_d.low = |b_bits[2:0];
  end

  assign ch1_in = '{dvs: (b_q.ra == 8'd0) ? 8'd1 : b_q.ra, rem: 8'd0,
                    dvd: b_q.val, quo: 32'd0};

  pisc_div_chain u_row_div (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .ctx_i (b_q), .div_i (ch1_in), .ctx_o (ch1_ctx), .div_o (ch1_div)
  );

  // Round the row up and scale back to bytes
  always_comb begin
    c_d     = ch1_ctx;
    c_ceil  = {1'b0, ch1_div.quo} + 33'((ch1_div.rem != 8'd0) || ch1_ctx.low);
    c_rowp  = 41'(c_ceil) * 41'(ch1_ctx.ra);
    c_d.val = c_rowp[31:0];
    c_d.ov  = ch1_ctx.ov || (|c_rowp[40:32]);
  end

  // Row times height
  always_comb begin
    d_d     = c_q;
    d_prod  = DimProdW'(c_q.val) * DimProdW'(c_q.h);
    d_d.val = d_prod[31:0];
    d_d.ov  = c_q.ov || (|d_prod[DimProdW-1:32]);
  end

  // Bias up by slice alignment less one
  always_comb begin
    e_d     = d_q;
    e_sum   = {1'b0, d_q.val} + 33'((d_q.sa == 8'd0) ? 8'd0 : d_q.sa - 8'd1);
    e_d.val = e_sum[31:0];
    e_d.ov  = d_q.ov || e_sum[32];
  end

  assign ch2_in = '{dvs: (e_q.sa == 8'd0) ? 8'd1 : e_q.sa, rem: 8'd0,
                    dvd: e_q.val, quo: 32'd0};

  pisc_div_chain u_slice_div (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .ctx_i (e_q), .div_i (ch2_in), .ctx_o (ch2_ctx), .div_o (ch2_div)
  );

  // Drop the remainder
  always_comb begin
    f_d     = ch2_ctx;
    f_d.val = ch2_ctx.val - 32'(ch2_div.rem);
  end

  // Slice times depth
  always_comb begin
    g_d     = f_q;
    g_prod  = DimProdW'(f_q.val) * DimProdW'(f_q.d);
    g_d.val = g_prod[31:0];
    g_d.ov  = f_q.ov || (|g_prod[DimProdW-1:32]);
  end

  // Bias up by image alignment less one
  always_comb begin
    h_d     = g_q;
    h_sum   = {1'b0, g_q.val} + 33'((g_q.ia == 8'd0) ? 8'd0 : g_q.ia - 8'd1);
    h_d.val = h_sum[31:0];
    h_d.ov  = g_q.ov || h_sum[32];
  end

  assign ch3_in = '{dvs: (h_q.ia == 8'd0) ? 8'd1 : h_q.ia, rem: 8'd0,
                    dvd: h_q.val, quo: 32'd0};

  pisc_div_chain u_image_div (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .ctx_i (h_q), .div_i (ch3_in), .ctx_o (ch3_ctx), .div_o (ch3_div)
  );

  // Drop the remainder, clamp to the row alignment, zero for empty images
  always_comb begin
    fin_size = ch3_ctx.val - 32'(ch3_div.rem);
    if (fin_size < 32'(ch3_ctx.ra)) begin
      fin_size = 32'(ch3_ctx.ra);
    end
    if (ch3_ctx.zero) begin
      fin_size = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      c_q <= '0;
      d_q <= '0;
      e_q <= '0;
      f_q <= '0;
      g_q <= '0;
      h_q <= '0;
    end else if (en) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      d_q <= d_d;
      e_q <= e_d;
      f_q <= f_d;
      g_q <= g_d;
      h_q <= h_d;
    end
  end

  // Output register: load from the tail, drop once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en && ch3_ctx.vld) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && ch3_ctx.vld) begin
      out_size_q <= fin_size;
      out_ov_q   <= ch3_ctx.ov && !ch3_ctx.zero;
    end
  end

  assign out_valid_o  = out_v_q;
  assign size_bytes_o = out_size_q;
  assign overflow_o   = out_ov_q;

endmodule

>>> hdl/pisc_checker.sv
module pisc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [31:0]                  size_bytes_o,
  input logic                         overflow_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(size_bytes_o)
      && $stable(overflow_o))
    else $error("stalled result changed");

  // Never stall the input while the output register is empty
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // Take input whenever a result leaves
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |-> !in_stall_o)
    else $error("input stalled during output transfer");

endmodule

bind packed_image_size_calculator pisc_checker u_pisc_checker (.*);

>>> bench/size_checker.sv
`timescale 1ns / 100ps

module size_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [pisc_pkg::DimBits-1:0] width_i,
  input  logic [pisc_pkg::DimBits-1:0] height_i,
  input  logic [pisc_pkg::DimBits-1:0] depth_i,
  input  logic [2:0]                   format_code_i,
  input  logic [3:0]                   type_code_i,
  input  logic [7:0]                   row_align_i,
  input  logic [7:0]                   slice_align_i,
  input  logic [7:0]                   image_align_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [31:0]                  size_bytes_i,
  input  logic                         overflow_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import pisc_pkg::*;

  typedef struct packed {
    logic [31:0] size;
    logic        ov;
  } image_size_t;

  image_size_t expected_sizes[$];

  function automatic logic [7:0] pixel_bits(logic [2:0] fmt, logic [3:0] typ);
    logic [7:0] comps;
    case (fmt)
      FmtDepth, FmtDepth16, FmtAlpha, FmtLum: comps = 8'd1;
      FmtRgb:      comps = 8'd3;
      FmtRgba:     comps = 8'd4;
      FmtLumAlpha: comps = 8'd2;
      default:     comps = 8'd0;
    endcase
    case (typ)
      TypByte, TypUbyte:         return comps * 8'd8;
      TypShort, TypUshort:       return comps * 8'd16;
      TypInt, TypUint, TypFloat: return comps * 8'd32;
      Typ565, Typ4444, Typ5551:  return 8'd16;
      default:                   return 8'd0;
    endcase
  endfunction

  // Cut to 32 bits, flag lost bits.
  function automatic logic [31:0] wrap32(logic [63:0] v, ref logic ov);
    if (v[63:32] != 0) ov = 1'b1;
    return v[31:0];
  endfunction

  function automatic logic [31:0] align_up(logic [31:0] v, logic [7:0] align, ref logic ov);
    logic [31:0] a;
    logic [31:0] s;
    a = (align == 0) ? 32'd1 : {24'd0, align};
    s = wrap32({32'd0, v} + {32'd0, a - 32'd1}, ov);
    return s - (s % a);
  endfunction

  function automatic image_size_t packed_size(
    logic [DimBits-1:0] w, logic [DimBits-1:0] h, logic [DimBits-1:0] d,
    logic [2:0] fmt, logic [3:0] typ, logic [7:0] ra, logic [7:0] sa, logic [7:0] ia);
    image_size_t r;
    logic        ov;
    logic [31:0] bits;
    logic [31:0] unit;
    logic [31:0] rows;
    logic [31:0] sz;
    ov = 1'b0;
    if (w == 0 || h == 0 || d == 0) begin
      r.size = '0;
      r.ov = 1'b0;
      return r;
    end
    bits = wrap32(64'(w) * 64'(pixel_bits(fmt, typ)), ov);
    unit = (ra != 0) ? 32'(ra) * 32'd8 : 32'd8;
    rows = bits / unit + ((bits % unit) != 0 ? 32'd1 : 32'd0);
    rows = wrap32(64'(rows) * 64'(ra), ov);
    sz = wrap32(64'(rows) * 64'(h), ov);
    sz = align_up(sz, sa, ov);
    sz = wrap32(64'(sz) * 64'(d), ov);
    sz = align_up(sz, ia, ov);
    if (sz < 32'(ra)) sz = 32'(ra);
    r.size = sz;
    r.ov = ov;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  assign pending_o = expected_sizes.size();

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    image_size_t want;
    if (rst_ni) begin
      // Check the result side first so a same-cycle input cannot be taken for it.
      if (out_valid_i && !out_stall_i) begin
        if (expected_sizes.size() == 0) begin
          report_mismatch($sformatf("unexpected result size=%0d", size_bytes_i));
        end else begin
          want = expected_sizes.pop_front();
          if (size_bytes_i !== want.size)
            report_mismatch($sformatf("size %0d, want %0d", size_bytes_i, want.size));
          if (overflow_i !== want.ov)
            report_mismatch($sformatf("overflow %b, want %b", overflow_i, want.ov));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_sizes.push_back(packed_size(width_i, height_i, depth_i, format_code_i,
                                             type_code_i, row_align_i, slice_align_i,
                                             image_align_i));
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import pisc_pkg::*;

  localparam int unsigned RandomItems = 1900;
  localparam int unsigned Latency = 105;
  // Idle cycles allowed with no transfer: long hold-off plus full pipeline.
  localparam int unsigned WatchdogLimit = 3000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [DimBits-1:0] width_i = '0;
  logic [DimBits-1:0] height_i = '0;
  logic [DimBits-1:0] depth_i = '0;
  logic [2:0]         format_code_i = '0;
  logic [3:0]         type_code_i = '0;
  logic [7:0]         row_align_i = '0;
  logic [7:0]         slice_align_i = '0;
  logic [7:0]         image_align_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  logic [31:0]        size_bytes_o;
  logic               overflow_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;   // no idling on either side while set
  bit          hold_off = 1'b0; // receiver stalls throughout while set

  always #6 clk_i = ~clk_i;

  packed_image_size_calculator uut (.*);

  size_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .width_i, .height_i, .depth_i, .format_code_i, .type_code_i,
    .row_align_i, .slice_align_i, .image_align_i,
    .out_valid_i(out_valid_o), .out_stall_i, .size_bytes_i(size_bytes_o),
    .overflow_i(overflow_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Hold one descriptor until it is transferred; idle at random first.
  task automatic send_image(logic [DimBits-1:0] w, logic [DimBits-1:0] h,
                            logic [DimBits-1:0] d, logic [2:0] fmt, logic [3:0] typ,
                            logic [7:0] ra, logic [7:0] sa, logic [7:0] ia);
    while (!steady && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    width_i <= w;
    height_i <= h;
    depth_i <= d;
    format_code_i <= fmt;
    type_code_i <= typ;
    row_align_i <= ra;
    slice_align_i <= sa;
    image_align_i <= ia;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Mostly small dimensions, half the row alignments a power of two, with full-range noise.
  task automatic send_random_image();
    logic [DimBits-1:0] w, h, d;
    logic [7:0]         ra;
    if ($urandom_range(3) != 0) begin
      w = DimBits'($urandom_range(1, 300));
      h = DimBits'($urandom_range(1, 300));
      d = DimBits'($urandom_range(1, 16));
    end else begin
      w = DimBits'($urandom);
      h = DimBits'($urandom);
      d = DimBits'($urandom);
    end
    if ($urandom_range(9) == 0) w = '0;
    ra = ($urandom_range(1) != 0) ? 8'(1 << $urandom_range(3)) : 8'($urandom);
    send_image(w, h, d, 3'($urandom), 4'($urandom), ra, 8'($urandom),
               8'($urandom));
  endtask

  // Receiver: random stalls, one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_off)
      out_stall_i <= 1'b1;
    else if (steady)
      out_stall_i <= 1'b0;
    else
      out_stall_i <= ($urandom_range(99) < 10);
  end

  // Watchdog: count cycles without a transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every format and type, zero dimensions, wraps.
    send_image(16'hFFFF, 16'hFFFF, 16'hFFFF, FmtRgba, TypFloat, 8'hFF, 8'hFF, 8'hFF);
    send_image(0, 5, 5, FmtRgb, TypByte, 4, 4, 4);
    send_image(5, 0, 5, FmtRgb, TypByte, 4, 4, 4);
    send_image(5, 5, 0, FmtRgb, TypByte, 4, 4, 4);
    send_image(1, 1, 1, 3'd7, TypByte, 8, 1, 1);
    send_image(3, 3, 3, FmtRgba, 4'd10, 4, 1, 1);
    send_image(3, 3, 3, FmtRgba, 4'd15, 4, 1, 1);
    send_image(7, 3, 2, FmtAlpha, TypUbyte, 0, 16, 32);
    send_image(9, 9, 9, FmtLum, Typ565, 4, 0, 0);
    send_image(9, 9, 9, FmtLumAlpha, Typ4444, 2, 3, 5);
    send_image(9, 9, 9, FmtDepth, Typ5551, 1, 7, 11);
    send_image(11, 5, 3, FmtDepth16, TypShort, 8, 1, 1);
    send_image(11, 5, 3, FmtDepth, TypUshort, 4, 1, 1);
    send_image(11, 5, 3, FmtRgb, TypInt, 8, 1, 1);
    send_image(11, 5, 3, FmtRgb, TypUint, 255, 255, 255);
    send_image(16'hFFFF, 16'hFFFF, 1, FmtRgba, TypFloat, 8, 1, 1);
    send_image(1, 1, 1, FmtRgb, TypByte, 255, 1, 1);
    send_image(16'hAAAA, 16'h5555, 16'h00FF, 3'd7, 4'd15, 8'hAA, 8'h55, 8'hAA);
    send_image(16'h5555, 16'hAAAA, 16'hFF00, FmtLumAlpha, TypShort, 8'h55, 8'hAA, 8'h55);

    // Long hold-off while the sender keeps offering, so the pipeline fills.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (300) send_random_image();
    join

    // Stretch with no idling at all.
    steady = 1'b1;
    repeat (300) send_random_image();
    steady = 1'b0;
    repeat (RandomItems - 600) send_random_image();

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
    if (fail_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
